@@ src/lph_pkg.sv @@
// Shared types and constants for the linear probe hash table.
`timescale 1ns / 1ps
package lph_pkg;

  localparam int KEY_W   = 31;
  localparam int SLOT_W  = 10;
  // Entries in the queue between front and back.
  localparam int Q_DEPTH = 2;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_SEARCH = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef struct packed {
    cmd_e             command;
    logic [KEY_W-1:0] key;
  } in_beat_t;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
  } out_beat_t;

endpackage

@@ src/lph_front.sv @@
// Front end: accepts beats and reduces each key to its home slot.
`timescale 1ns / 1ps
module lph_front #(
  parameter int TABLE_SIZE = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lph_pkg::in_beat_t in_beat_i,
  input  logic             clearing_i,
  input  logic             q_ready_i,
  output logic             q_push_o,
  output lph_pkg::in_beat_t q_beat_o,
  output logic [$clog2(TABLE_SIZE)-1:0] q_home_o
);
  import lph_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_SIZE);
  // key * RECIP >> SHIFT is the exact quotient for every key below 2**KEY_W.
  localparam int SHIFT  = KEY_W + IDX_W;
  localparam int RCP_W  = KEY_W + 1;
  // Product bits up to the low quotient bits; higher bits are never needed.
  localparam int PROD_W = SHIFT + IDX_W;
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
  localparam logic [RCP_W-1:0] RECIP = RCP_W'(RECIP_WIDE);
  localparam logic [IDX_W-1:0] N_LOW = IDX_W'(TABLE_SIZE);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_SUB  = 2'd2;

  logic [1:0]        state_q, state_d;
  in_beat_t          beat_q, beat_d;
  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  quo_q, quo_d, qn_low;
  logic              accept;

  // 31 x 32 bit multiply by the reciprocal; keep only the low quotient bits.
  assign prod   = PROD_W'(beat_q.key) * PROD_W'(RECIP);
  assign quo_d  = prod[PROD_W-1 -: IDX_W];
  // The remainder is below TABLE_SIZE, so key - quotient * TABLE_SIZE is
  // exact when taken in the low IDX_W bits only.
  assign qn_low = quo_q * N_LOW;

  assign q_home_o = beat_q.key[IDX_W-1:0] - qn_low;
  assign q_push_o = (state_q == F_SUB) && q_ready_i;
  assign q_beat_o = beat_q;
  // Take a new beat when idle or as the current one leaves for the queue, but not while clearing.
  assign in_ready_o = !clearing_i && ((state_q == F_IDLE) || q_push_o);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    beat_d  = beat_q;
    unique case (state_q)
      F_MUL: begin
        state_d = F_SUB;
      end
      F_SUB: begin
        if (q_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
    if (accept) begin
      beat_d  = in_beat_i;
      state_d = F_MUL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
    quo_q  <= quo_d;
  end

endmodule

@@ src/lph_queue.sv @@
// Short FIFO between the front end and the probe engine.
`timescale 1ns / 1ps
module lph_queue #(
  parameter int DATA_W = 42
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              ready_o,
  input  logic [DATA_W-1:0] data_i,
  output logic              valid_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] data_o
);
  import lph_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(Q_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(Q_DEPTH);

  logic [DATA_W-1:0] entry_q [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign ready_o = (cnt_q != FULL_CNT);
  assign valid_o = (cnt_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ src/lph_back.sv @@
// Probe engine: slot memory, clearing pass, probe sequencer and result register.
`timescale 1ns / 1ps
module lph_back #(
  parameter int TABLE_SIZE = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_pop_o,
  input  lph_pkg::in_beat_t q_beat_i,
  input  logic [$clog2(TABLE_SIZE)-1:0] q_home_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lph_pkg::out_beat_t out_beat_o,
  output logic              clearing_o
);
  import lph_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int ENT_W = KEY_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

  localparam logic [1:0] B_CLEAR = 2'd0;
  localparam logic [1:0] B_IDLE  = 2'd1;
  localparam logic [1:0] B_PROBE = 2'd2;

  // Each entry holds {used, key}.
  logic [ENT_W-1:0] mem [TABLE_SIZE];
  logic [ENT_W-1:0] rdata_q;

  logic [1:0]       state_q, state_d;
  in_beat_t         cur_q, cur_d;
  logic [IDX_W-1:0] idx_q, idx_d, n_q, n_d, clr_q, clr_d, idx_next;
  logic             out_valid_q, out_valid_d;
  out_beat_t        out_q, out_d;

  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [ENT_W-1:0] wr_data;

  logic             stored_used, key_eq, last_probe, stop, store, out_free;
  logic [KEY_W-1:0] stored_key;
  status_e          res_status;
  logic [SLOT_W-1:0] res_slot;

  assign stored_used = rdata_q[KEY_W];
  assign stored_key  = rdata_q[KEY_W-1:0];
  assign key_eq      = (stored_key == cur_q.key);
  assign last_probe  = (n_q == LAST_IDX);
  assign idx_next    = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;

  // Classify the slot just read.
  always_comb begin
    stop       = 1'b1;
    store      = 1'b0;
    res_status = ST_NOT_FOUND;
    res_slot   = '0;
    if (cur_q.command == CMD_INSERT) begin
      priority if (!stored_used || (stored_key == '0)) begin
        store      = 1'b1;
        res_status = ST_INSERTED;
        res_slot   = SLOT_W'(idx_q);
      end else if (key_eq) begin
        res_status = ST_DUPLICATE;
      end else if (last_probe) begin
        res_status = ST_FULL;
      end else begin
        stop = 1'b0;
      end
    end else begin
      priority if (!stored_used) begin
        res_status = ST_NOT_FOUND;
      end else if (key_eq) begin
        res_status = ST_FOUND;
        res_slot   = SLOT_W'(idx_q);
      end else if (last_probe) begin
        res_status = ST_NOT_FOUND;
      end else begin
        stop = 1'b0;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    n_d         = n_q;
    clr_d       = clr_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    q_pop_o     = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;
    unique case (state_q)
      B_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + 1'b1;
        if (clr_q == LAST_IDX) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          rd_en   = 1'b1;
          rd_addr = q_home_i;
          cur_d   = q_beat_i;
          idx_d   = q_home_i;
          n_d     = '0;
          state_d = B_PROBE;
        end
      end
      B_PROBE: begin
        if (!stop) begin
          rd_en   = 1'b1;
          rd_addr = idx_next;
          idx_d   = idx_next;
          n_d     = n_q + 1'b1;
        end else if (out_free) begin
          out_valid_d   = 1'b1;
          out_d.status  = res_status;
          out_d.slot    = res_slot;
          wr_en         = store;
          wr_addr       = idx_q;
          wr_data       = {1'b1, cur_q.key};
          state_d       = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    idx_q <= idx_d;
    n_q   <= n_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;
  assign clearing_o  = (state_q == B_CLEAR);

endmodule

@@ src/linear_probe_hash_table.sv @@
// Top level of the linear probe hash table: front end, queue and probe engine.
//
//   channel | direction | handshake               | beat
//   --------+-----------+-------------------------+----------------------------
//   in      | input     | in_valid_i / in_ready_o   | in_beat_i  {command, key}
//   out     | output    | out_valid_o / out_ready_i | out_beat_o {status, slot}
//
// Flow: the front end gets key mod TABLE_SIZE by a reciprocal multiply, then a
//   low-bit subtract, and takes a new beat as the last leaves for the queue; the
//   probe engine pops a beat, probes slot by slot, and so sets the pace.
// Reset: a clearing pass writes every slot empty, with in_ready_o low.
// Stalls: a two-entry queue lets the front end keep accepting while the engine
//   probes; the result register takes one more beat while out_ready_i is low.
`timescale 1ns / 1ps
module linear_probe_hash_table #(
  parameter int TABLE_SIZE = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lph_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lph_pkg::out_beat_t out_beat_o
);
  import lph_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_SIZE);
  localparam int BEAT_W = $bits(in_beat_t);
  localparam int Q_W    = BEAT_W + IDX_W;

  // Front end to queue.
  logic             f_push, q_ready;
  in_beat_t         f_beat;
  logic [IDX_W-1:0] f_home;

  // Queue to probe engine.
  logic             q_valid, q_pop;
  logic [Q_W-1:0]   q_wdata, q_rdata;
  in_beat_t         b_beat;
  logic [IDX_W-1:0] b_home;

  // Engine is sweeping the slot memory after reset.
  logic             clearing;

  lph_front #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_beat_i  (in_beat_i),
    .clearing_i (clearing),
    .q_ready_i  (q_ready),
    .q_push_o   (f_push),
    .q_beat_o   (f_beat),
    .q_home_o   (f_home)
  );

  assign q_wdata = {f_beat, f_home};

  lph_queue #(
    .DATA_W(Q_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .ready_o (q_ready),
    .data_i  (q_wdata),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_rdata)
  );

  assign b_beat = q_rdata[Q_W-1 -: BEAT_W];
  assign b_home = q_rdata[IDX_W-1:0];

  lph_back #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_beat_i    (b_beat),
    .q_home_i    (b_home),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o),
    .clearing_o  (clearing)
  );

`ifndef SYNTHESIS
  // No beat may enter while the slot memory is still being swept.
  a_no_accept_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) clearing |-> !in_ready_o
  ) else $error("input accepted during clearing pass");

  // Nothing can be in flight during the clearing pass.
  a_no_result_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) clearing |-> (!out_valid_o && !q_valid)
  ) else $error("work in flight during clearing pass");

  // Misses, duplicates and full-table results carry slot zero.
  a_slot_zero_on_miss: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && (out_beat_o.status == ST_DUPLICATE ||
                       out_beat_o.status == ST_FULL ||
                       out_beat_o.status == ST_NOT_FOUND))
      |-> (out_beat_o.slot == '0)
  ) else $error("nonzero slot on a result without a slot");
`endif

endmodule
